/* src/pon_pkg.sv */
// Shared constants, types and codes for the octave gradient noise unit.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none
package pon_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int MAX_OCTAVES = 8;

    localparam int CRD_W   = FRAC_BITS + 8;
    localparam int OP_W    = FRAC_BITS + 6;
    localparam int PROD_W  = 2 * OP_W;
    localparam int GRAD_W  = FRAC_BITS + 2;
    localparam int FADE_W  = FRAC_BITS + 2;
    localparam int G_W     = FRAC_BITS + 5;
    localparam int OUT_W   = 20;
    localparam int SUM_W   = (GRAD_W + 2 > OUT_W + 1) ? GRAD_W + 2 : OUT_W + 1;
    localparam int K_W     = $clog2(MAX_OCTAVES + 1);
    localparam int Q_DEPTH = 8;
    localparam int QN_W    = $clog2(Q_DEPTH + 1);
    localparam int Q_IW    = $clog2(Q_DEPTH);
    localparam int STEP_W  = 4;
    localparam int HASH_W  = 8;
    localparam int PERM_DEPTH = 256;

    localparam int OUT_MAX = (1 << (OUT_W - 1)) - 1;
    localparam int OUT_MIN = -(1 << (OUT_W - 1));

    localparam logic signed [GRAD_W-1:0] ONE_G   = GRAD_W'(1 << FRAC_BITS);
    localparam logic signed [OP_W-1:0]   FIFTEEN = OP_W'(15 << FRAC_BITS);
    localparam logic signed [OP_W-1:0]   TEN     = OP_W'(10 << FRAC_BITS);

    localparam logic REQ_TABLE = 1'b0;
    localparam logic REQ_NOISE = 1'b1;

    localparam logic [STEP_W-1:0] RD_GRAD0  = 4'd6;
    localparam logic [STEP_W-1:0] RD_LAST   = 4'd13;
    localparam logic [STEP_W-1:0] LERP_LAST = 4'd6;
    localparam logic [STEP_W-1:0] LERP_U    = 4'd4;
    localparam logic [STEP_W-1:0] LERP_V    = 4'd6;

    localparam logic [1:0] FOP_SQ   = 2'd0;
    localparam logic [1:0] FOP_CUBE = 2'd1;
    localparam logic [1:0] FOP_POLY = 2'd2;
    localparam logic [1:0] FOP_FADE = 2'd3;
    localparam logic [1:0] CRD_LAST = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RADDR,
        S_RDATA,
        S_FISSUE,
        S_FWB,
        S_LISSUE,
        S_LWB,
        S_ACC,
        S_DONE
    } t_state;

    typedef struct packed {
        logic signed [OP_W-1:0] mul_a;
        logic signed [OP_W-1:0] mul_b;
        logic signed [OP_W-1:0] add_c;
    } t_mac_req;

endpackage
`default_nettype wire

/* src/pon_mac.sv */
// Shared multiply, floor-shift and add unit: result = (a*b >>> FRAC_BITS) + c.
// Product registered on load; result valid the cycle after. Uses pon_pkg.
`default_nettype none
module pon_mac (
    input  wire logic                          i_clk,
    input  wire logic                          i_load,
    input  wire pon_pkg::t_mac_req             i_req,
    output logic signed [pon_pkg::OP_W-1:0]    o_result
);

    logic signed [pon_pkg::PROD_W-1:0] r_prod;
    logic signed [pon_pkg::OP_W-1:0]   r_add;
    logic signed [pon_pkg::PROD_W-1:0] w_shift;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= $signed(i_req.mul_a) * $signed(i_req.mul_b);
            r_add  <= i_req.add_c;
        end
    end

    assign w_shift  = r_prod >>> pon_pkg::FRAC_BITS;
    assign o_result = w_shift[pon_pkg::OP_W-1:0] + r_add;

endmodule
`default_nettype wire

/* src/pon_perm.sv */
// Permutation store: 256 x 8 memory, one write port, one registered read port.
// Uses pon_pkg for depth and width.
`default_nettype none
module pon_perm (
    input  wire logic                          i_clk,
    input  wire logic                          i_we,
    input  wire logic [pon_pkg::HASH_W-1:0]    i_waddr,
    input  wire logic [pon_pkg::HASH_W-1:0]    i_wdata,
    input  wire logic [pon_pkg::HASH_W-1:0]    i_raddr,
    output logic      [pon_pkg::HASH_W-1:0]    o_rdata
);

    logic [pon_pkg::HASH_W-1:0] r_mem [pon_pkg::PERM_DEPTH];
    logic [pon_pkg::HASH_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* src/perlin_octave_noise_3d_unit.sv */
// Top level: sequencer for octave gradient noise around one shared multiply unit.
// Instantiates pon_perm and pon_mac; uses pon_pkg.
//
//   channel  valid    stall    payload
//   request  i_valid  o_stall  i_req_type i_table_index i_table_value i_x/y/z_pos i_octave_count
//   result   o_valid  i_stall  o_noise_value o_is_table_ack
//
// Table write: goes to S_DONE, then is posted to the result register. Query, per octave:
// 14 permutation reads (S_RADDR, S_RDATA), 12 fade and 7 lerp operations on the shared
// multiplier (issue and write-back states), 1 accumulate, serialised by the single multiplier and read port.
// o_stall is high from acceptance until the result is posted to the output register.
// Reset is synchronous; the permutation store is not cleared.
`default_nettype none
module perlin_octave_noise_3d_unit (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_stall,
    input  wire logic                                 i_req_type,
    input  wire logic [7:0]                           i_table_index,
    input  wire logic [7:0]                           i_table_value,
    input  wire logic signed [31:0]                   i_x_pos,
    input  wire logic signed [31:0]                   i_y_pos,
    input  wire logic signed [31:0]                   i_z_pos,
    input  wire logic [3:0]                           i_octave_count,
    output logic                                      o_valid,
    input  wire logic                                 i_stall,
    output logic signed [pon_pkg::OUT_W-1:0]          o_noise_value,
    output logic                                      o_is_table_ack
);

    localparam int F = pon_pkg::FRAC_BITS;

    pon_pkg::t_state r_state;
    pon_pkg::t_state n_state;

    logic [pon_pkg::CRD_W-1:0]  r_x;
    logic [pon_pkg::CRD_W-1:0]  r_y;
    logic [pon_pkg::CRD_W-1:0]  r_z;
    logic [pon_pkg::K_W-1:0]    r_noct;
    logic [pon_pkg::K_W-1:0]    r_k;
    logic [pon_pkg::STEP_W-1:0] r_step;
    logic [1:0]                 r_c;
    logic [pon_pkg::QN_W-1:0]   r_qn;
    logic [pon_pkg::HASH_W-1:0] r_pa;
    logic [pon_pkg::HASH_W-1:0] r_pb;
    logic [pon_pkg::HASH_W-1:0] r_aa;
    logic [pon_pkg::HASH_W-1:0] r_ab;
    logic [pon_pkg::HASH_W-1:0] r_ba;
    logic [pon_pkg::HASH_W-1:0] r_bb;
    logic [F-1:0]               r_t2;
    logic [F-1:0]               r_t3;
    logic signed [pon_pkg::G_W-1:0]    r_g;
    logic signed [pon_pkg::FADE_W-1:0] r_fade [3];
    logic signed [pon_pkg::GRAD_W-1:0] r_q [pon_pkg::Q_DEPTH];
    logic signed [pon_pkg::SUM_W-1:0]  r_sum;
    logic                              r_ovalid;
    logic signed [pon_pkg::OUT_W-1:0]  r_noise;
    logic                              r_ack;
    logic                              r_oack;

    logic                              w_in_acc;
    logic                              w_out_free;
    logic                              w_perm_we;
    logic                              w_mac_load;
    logic [4:0]                        w_oct5;
    logic [pon_pkg::K_W-1:0]           w_noct;
    logic [pon_pkg::HASH_W-1:0]        w_cx;
    logic [pon_pkg::HASH_W-1:0]        w_cy;
    logic [pon_pkg::HASH_W-1:0]        w_cz;
    logic [pon_pkg::HASH_W-1:0]        w_raddr;
    logic [pon_pkg::HASH_W-1:0]        w_rdata;
    logic [F-1:0]                      w_frac;
    logic signed [pon_pkg::OP_W-1:0]   w_t;
    logic signed [pon_pkg::OP_W-1:0]   w_lt;
    pon_pkg::t_mac_req                 w_req;
    logic signed [pon_pkg::OP_W-1:0]   w_res;
    logic [2:0]                        w_gi;
    logic [3:0]                        w_h;
    logic signed [pon_pkg::GRAD_W-1:0] w_gx;
    logic signed [pon_pkg::GRAD_W-1:0] w_gy;
    logic signed [pon_pkg::GRAD_W-1:0] w_gz;
    logic signed [pon_pkg::GRAD_W-1:0] w_gu;
    logic signed [pon_pkg::GRAD_W-1:0] w_gv;
    logic signed [pon_pkg::GRAD_W-1:0] w_grad;
    logic signed [pon_pkg::GRAD_W-1:0] w_nsh;
    logic [pon_pkg::Q_IW-1:0]          w_qw;
    logic [pon_pkg::QN_W-1:0]          w_qm2;
    logic signed [pon_pkg::OUT_W-1:0]  w_sat;

    assign w_in_acc   = i_valid && !o_stall;
    assign w_out_free = !r_ovalid || !i_stall;
    assign w_perm_we  = w_in_acc && (i_req_type == pon_pkg::REQ_TABLE);

    assign w_oct5 = {1'b0, i_octave_count};
    assign w_noct = (w_oct5 > 5'(pon_pkg::MAX_OCTAVES)) ?
                    pon_pkg::K_W'(pon_pkg::MAX_OCTAVES) : pon_pkg::K_W'(w_oct5);

    assign w_cx = r_x[pon_pkg::CRD_W-1:F];
    assign w_cy = r_y[pon_pkg::CRD_W-1:F];
    assign w_cz = r_z[pon_pkg::CRD_W-1:F];

    pon_perm u_perm (
        .i_clk   (i_clk),
        .i_we    (w_perm_we),
        .i_waddr (i_table_index),
        .i_wdata (i_table_value),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        case (r_step)
            4'd0:    w_raddr = w_cx;
            4'd1:    w_raddr = w_cx + 8'd1;
            4'd2:    w_raddr = r_pa + w_cy;
            4'd3:    w_raddr = r_pa + w_cy + 8'd1;
            4'd4:    w_raddr = r_pb + w_cy;
            4'd5:    w_raddr = r_pb + w_cy + 8'd1;
            4'd6:    w_raddr = r_aa;
            4'd7:    w_raddr = r_ba;
            4'd8:    w_raddr = r_ab;
            4'd9:    w_raddr = r_bb;
            4'd10:   w_raddr = r_aa + 8'd1;
            4'd11:   w_raddr = r_ba + 8'd1;
            4'd12:   w_raddr = r_ab + 8'd1;
            4'd13:   w_raddr = r_bb + 8'd1;
            default: w_raddr = '0;
        endcase
    end

    assign w_gi = 3'(r_step - pon_pkg::RD_GRAD0);
    assign w_h  = w_rdata[3:0];
    assign w_gx = w_gi[0] ? $signed(pon_pkg::GRAD_W'(r_x[F-1:0])) - pon_pkg::ONE_G
                          : $signed(pon_pkg::GRAD_W'(r_x[F-1:0]));
    assign w_gy = w_gi[1] ? $signed(pon_pkg::GRAD_W'(r_y[F-1:0])) - pon_pkg::ONE_G
                          : $signed(pon_pkg::GRAD_W'(r_y[F-1:0]));
    assign w_gz = w_gi[2] ? $signed(pon_pkg::GRAD_W'(r_z[F-1:0])) - pon_pkg::ONE_G
                          : $signed(pon_pkg::GRAD_W'(r_z[F-1:0]));
    assign w_gu = (w_h < 4'd8) ? w_gx : w_gy;
    assign w_gv = (w_h < 4'd4) ? w_gy :
                  ((w_h == 4'd12 || w_h == 4'd14) ? w_gx : w_gz);
    assign w_grad = (w_h[0] ? -w_gu : w_gu) + (w_h[1] ? -w_gv : w_gv);

    always_comb begin
        case (r_c)
            2'd0:    w_frac = r_x[F-1:0];
            2'd1:    w_frac = r_y[F-1:0];
            default: w_frac = r_z[F-1:0];
        endcase
    end
    assign w_t = $signed(pon_pkg::OP_W'(w_frac));

    always_comb begin
        if (r_step < pon_pkg::LERP_U) begin
            w_lt = pon_pkg::OP_W'(r_fade[0]);
        end else if (r_step < pon_pkg::LERP_V) begin
            w_lt = pon_pkg::OP_W'(r_fade[1]);
        end else begin
            w_lt = pon_pkg::OP_W'(r_fade[2]);
        end
    end

    always_comb begin
        w_req.mul_a = w_lt;
        w_req.mul_b = pon_pkg::OP_W'(r_q[1]) - pon_pkg::OP_W'(r_q[0]);
        w_req.add_c = pon_pkg::OP_W'(r_q[0]);
        if (r_state == pon_pkg::S_FISSUE) begin
            case (r_step[1:0])
                pon_pkg::FOP_SQ: begin
                    w_req.mul_a = w_t;
                    w_req.mul_b = w_t;
                    w_req.add_c = '0;
                end
                pon_pkg::FOP_CUBE: begin
                    w_req.mul_a = $signed(pon_pkg::OP_W'(r_t2));
                    w_req.mul_b = w_t;
                    w_req.add_c = '0;
                end
                pon_pkg::FOP_POLY: begin
                    w_req.mul_a = w_t;
                    w_req.mul_b = (w_t <<< 2) + (w_t <<< 1) - pon_pkg::FIFTEEN;
                    w_req.add_c = pon_pkg::TEN;
                end
                default: begin
                    w_req.mul_a = $signed(pon_pkg::OP_W'(r_t3));
                    w_req.mul_b = pon_pkg::OP_W'(r_g);
                    w_req.add_c = '0;
                end
            endcase
        end
    end

    assign w_mac_load = (r_state == pon_pkg::S_FISSUE) || (r_state == pon_pkg::S_LISSUE);

    pon_mac u_mac (
        .i_clk    (i_clk),
        .i_load   (w_mac_load),
        .i_req    (w_req),
        .o_result (w_res)
    );

    assign w_qm2 = r_qn - pon_pkg::QN_W'(2);
    assign w_qw  = w_qm2[pon_pkg::Q_IW-1:0];
    assign w_nsh = r_q[0] >>> r_k;

    always_comb begin
        if (r_sum > pon_pkg::SUM_W'(pon_pkg::OUT_MAX)) begin
            w_sat = pon_pkg::OUT_W'(pon_pkg::OUT_MAX);
        end else if (r_sum < pon_pkg::SUM_W'(pon_pkg::OUT_MIN)) begin
            w_sat = pon_pkg::OUT_W'(pon_pkg::OUT_MIN);
        end else begin
            w_sat = r_sum[pon_pkg::OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pon_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_stall = 1'b1;
        case (r_state)
            pon_pkg::S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    if (i_req_type == pon_pkg::REQ_TABLE || w_noct == '0) begin
                        n_state = pon_pkg::S_DONE;
                    end else begin
                        n_state = pon_pkg::S_RADDR;
                    end
                end
            end
            pon_pkg::S_RADDR: n_state = pon_pkg::S_RDATA;
            pon_pkg::S_RDATA: begin
                n_state = (r_step == pon_pkg::RD_LAST) ? pon_pkg::S_FISSUE : pon_pkg::S_RADDR;
            end
            pon_pkg::S_FISSUE: n_state = pon_pkg::S_FWB;
            pon_pkg::S_FWB: begin
                if (r_step[1:0] == pon_pkg::FOP_FADE && r_c == pon_pkg::CRD_LAST) begin
                    n_state = pon_pkg::S_LISSUE;
                end else begin
                    n_state = pon_pkg::S_FISSUE;
                end
            end
            pon_pkg::S_LISSUE: n_state = pon_pkg::S_LWB;
            pon_pkg::S_LWB: begin
                n_state = (r_step == pon_pkg::LERP_LAST) ? pon_pkg::S_ACC : pon_pkg::S_LISSUE;
            end
            pon_pkg::S_ACC: begin
                n_state = (r_k + 1'b1 == r_noct) ? pon_pkg::S_DONE : pon_pkg::S_RADDR;
            end
            pon_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = pon_pkg::S_IDLE;
                end
            end
            default: n_state = pon_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
            r_c    <= '0;
            r_qn   <= '0;
            r_k    <= '0;
            r_noct <= '0;
        end else begin
            case (r_state)
                pon_pkg::S_IDLE: begin
                    if (w_in_acc) begin
                        r_x    <= i_x_pos[pon_pkg::CRD_W-1:0];
                        r_y    <= i_y_pos[pon_pkg::CRD_W-1:0];
                        r_z    <= i_z_pos[pon_pkg::CRD_W-1:0];
                        r_noct <= w_noct;
                        r_k    <= '0;
                        r_step <= '0;
                        r_qn   <= '0;
                        r_sum  <= '0;
                        r_ack  <= (i_req_type == pon_pkg::REQ_TABLE);
                    end
                end
                pon_pkg::S_RDATA: begin
                    case (r_step)
                        4'd0:    r_pa <= w_rdata;
                        4'd1:    r_pb <= w_rdata;
                        4'd2:    r_aa <= w_rdata + w_cz;
                        4'd3:    r_ab <= w_rdata + w_cz;
                        4'd4:    r_ba <= w_rdata + w_cz;
                        4'd5:    r_bb <= w_rdata + w_cz;
                        default: begin
                            r_q[r_qn[pon_pkg::Q_IW-1:0]] <= w_grad;
                            r_qn <= r_qn + 1'b1;
                        end
                    endcase
                    if (r_step == pon_pkg::RD_LAST) begin
                        r_step <= '0;
                        r_c    <= '0;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                pon_pkg::S_FWB: begin
                    case (r_step[1:0])
                        pon_pkg::FOP_SQ:   r_t2 <= w_res[F-1:0];
                        pon_pkg::FOP_CUBE: r_t3 <= w_res[F-1:0];
                        pon_pkg::FOP_POLY: r_g  <= w_res[pon_pkg::G_W-1:0];
                        default:           r_fade[r_c] <= w_res[pon_pkg::FADE_W-1:0];
                    endcase
                    if (r_step[1:0] == pon_pkg::FOP_FADE) begin
                        r_step <= '0;
                        r_c    <= r_c + 1'b1;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                pon_pkg::S_LWB: begin
                    for (int i = 0; i < pon_pkg::Q_DEPTH - 2; i++) begin
                        if (pon_pkg::Q_IW'(i) != w_qw) begin
                            r_q[i] <= r_q[i+2];
                        end
                    end
                    r_q[w_qw] <= w_res[pon_pkg::GRAD_W-1:0];
                    r_qn      <= r_qn - 1'b1;
                    r_step    <= r_step + 1'b1;
                end
                pon_pkg::S_ACC: begin
                    r_sum  <= r_sum + pon_pkg::SUM_W'(w_nsh);
                    r_x    <= r_x << 1;
                    r_y    <= r_y << 1;
                    r_z    <= r_z << 1;
                    r_k    <= r_k + 1'b1;
                    r_step <= '0;
                    r_qn   <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == pon_pkg::S_DONE && w_out_free) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == pon_pkg::S_DONE && w_out_free) begin
            r_noise <= r_ack ? '0 : w_sat;
            r_oack  <= r_ack;
        end
    end

    assign o_valid        = r_ovalid;
    assign o_noise_value  = r_noise;
    assign o_is_table_ack = r_oack;

    a_qn_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qn <= pon_pkg::QN_W'(pon_pkg::Q_DEPTH))
        else $error("operand queue overfilled");

    a_lerp_operands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == pon_pkg::S_LISSUE |-> r_qn >= pon_pkg::QN_W'(2))
        else $error("lerp issued without two operands");

    a_table_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && i_req_type == pon_pkg::REQ_TABLE |=> r_state == pon_pkg::S_DONE)
        else $error("table write did not post an acknowledge");

    a_ack_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_table_ack |-> o_noise_value == '0)
        else $error("table acknowledge carries nonzero noise");

    a_octave_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == pon_pkg::S_ACC |-> r_k < r_noct)
        else $error("octave counter past requested count");

endmodule
`default_nettype wire
